### rtl/core/signed_int_to_radix_digits_unit_macros.svh
// Assertion macros used by the port-level checker of the radix conversion unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SIGNED_INT_TO_RADIX_DIGITS_UNIT_MACROS_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIRDX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIRDX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sirdx_pkg.sv
// Shared types, constants and the symbol lookup for the radix conversion unit.
// No dependencies; every other file of the unit but the macro header refers to this package.
package sirdx_pkg;

  localparam int NUMBER_WIDTH = 32;
  localparam int MAX_RADIX    = 16;
  localparam int SYM_W        = 8;
  localparam int RADIX_W      = 5;
  localparam int DIGIT_W      = RADIX_W - 1;
  localparam int NUM_DIGITS   = NUMBER_WIDTH;
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int BCNT_W       = $clog2(NUMBER_WIDTH);
  localparam int DCNT_W       = $clog2(NUM_DIGITS + 1);

  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [CFG_W-1:0]   cfg_word_t;

  localparam sym_t      SIGN_PLUS       = 8'h2B;
  localparam sym_t      SIGN_MINUS      = 8'h2D;
  localparam radix_t    MIN_RADIX       = 5'd2;
  localparam radix_t    RADIX_RESET     = 5'd2;
  localparam cfg_word_t SYMS_LOW_RESET  = 64'h0000_0000_0000_3130;
  localparam cfg_word_t SYMS_HIGH_RESET = 64'h0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX     = 2'd0,
    CFG_SYMS_LOW  = 2'd1,
    CFG_SYMS_HIGH = 2'd2
  } cfg_idx_t;

  // Control from the sequencer to the digit array.
  typedef struct packed {
    logic load;   // take a new magnitude and clear the digits
    logic conv;   // shift one magnitude bit into the digits
    logic shift;  // move the digits one place toward the top
  } dig_ctl_t;

  // Symbols 0 to 7 sit in the low word, 8 to 15 in the high word.
  function automatic sym_t symbol_at(input cfg_word_t lo, input cfg_word_t hi,
                                     input digit_t d);
    cfg_word_t tbl;
    tbl = d[DIGIT_W-1] ? hi : lo;
    return tbl[{d[DIGIT_W-2:0], 3'b000} +: SYM_W];
  endfunction

endpackage

### rtl/core/sirdx_digits.sv
// Digit array of the radix conversion: magnitude bits enter MSB first and each
// cell doubles its digit in the configured radix. Depends on sirdx_pkg.
module sirdx_digits (
  input  logic                                clk,
  input  sirdx_pkg::dig_ctl_t                 ctl,
  input  logic [sirdx_pkg::NUMBER_WIDTH-1:0]  mag_in,
  input  sirdx_pkg::radix_t                   radix,
  output sirdx_pkg::digit_t                   top_digit
);

  logic [sirdx_pkg::NUMBER_WIDTH-1:0] mag_r;
  sirdx_pkg::digit_t                  dig_r   [sirdx_pkg::NUM_DIGITS];
  sirdx_pkg::digit_t                  dig_nxt [sirdx_pkg::NUM_DIGITS];

  logic [sirdx_pkg::NUM_DIGITS-1:0] gen;
  logic [sirdx_pkg::NUM_DIGITS-1:0] prop;
  logic [sirdx_pkg::NUM_DIGITS:0]   opa;
  logic [sirdx_pkg::NUM_DIGITS:0]   opb;
  logic [sirdx_pkg::NUM_DIGITS:0]   carry;

  // A cell overflows when twice its digit reaches the radix (generate), or
  // when it falls one short and the cell below overflows (propagate, odd
  // radix only). That is the carry chain of an adder, so one add resolves it.
  always_comb begin
    sirdx_pkg::radix_t t;
    for (int k = 0; k < sirdx_pkg::NUM_DIGITS; k++) begin
      gen[k]  = ({dig_r[k], 1'b0} >= radix);
      prop[k] = ({dig_r[k], 1'b1} == radix);
    end
    opa   = {1'b0, gen | prop};
    opb   = {1'b0, gen};
    carry = (opa + opb + {{sirdx_pkg::NUM_DIGITS{1'b0}},
                          mag_r[sirdx_pkg::NUMBER_WIDTH-1]}) ^ opa ^ opb;
    for (int k = 0; k < sirdx_pkg::NUM_DIGITS; k++) begin
      t          = {dig_r[k], carry[k]};
      dig_nxt[k] = carry[k+1] ? sirdx_pkg::digit_t'(t - radix)
                              : sirdx_pkg::digit_t'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag_r <= mag_in;
      for (int k = 0; k < sirdx_pkg::NUM_DIGITS; k++) dig_r[k] <= '0;
    end else if (ctl.conv) begin
      mag_r <= {mag_r[sirdx_pkg::NUMBER_WIDTH-2:0], 1'b0};
      for (int k = 0; k < sirdx_pkg::NUM_DIGITS; k++) dig_r[k] <= dig_nxt[k];
    end else if (ctl.shift) begin
      dig_r[0] <= '0;
      for (int k = 1; k < sirdx_pkg::NUM_DIGITS; k++) dig_r[k] <= dig_r[k-1];
    end
  end

  assign top_digit = dig_r[sirdx_pkg::NUM_DIGITS-1];

endmodule

### rtl/core/sirdx_symchk.sv
// Symbol table check: walks the symbols in use one per cycle, flagging sign
// bytes, duplicates and an out-of-range radix. Depends on sirdx_pkg.
module sirdx_symchk (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  sirdx_pkg::radix_t      radix,
  input  sirdx_pkg::cfg_word_t   syms_low,
  input  sirdx_pkg::cfg_word_t   syms_high,
  output logic                   bad
);

  sirdx_pkg::sym_t   sh_r [sirdx_pkg::MAX_RADIX];
  sirdx_pkg::radix_t left_r;
  logic              bad_r;
  logic              hit;
  logic              range_bad;

  assign range_bad = (radix < sirdx_pkg::MIN_RADIX) ||
                     (radix > sirdx_pkg::radix_t'(sirdx_pkg::MAX_RADIX));

  // The head of the line is checked for a sign byte and compared with every later symbol still in use.
  always_comb begin
    hit = (sh_r[0] == sirdx_pkg::SIGN_PLUS) || (sh_r[0] == sirdx_pkg::SIGN_MINUS);
    for (int k = 1; k < sirdx_pkg::MAX_RADIX; k++) begin
      if ((sirdx_pkg::radix_t'(k) < left_r) && (sh_r[k] == sh_r[0])) hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      bad_r  <= 1'b0;
    end else if (start) begin
      left_r <= range_bad ? '0 : radix;
      bad_r  <= range_bad;
    end else if (left_r != '0) begin
      left_r <= left_r - sirdx_pkg::radix_t'(1);
      bad_r  <= bad_r | hit;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int k = 0; k < sirdx_pkg::MAX_RADIX / 2; k++) begin
        sh_r[k]     <= syms_low[k*sirdx_pkg::SYM_W +: sirdx_pkg::SYM_W];
        sh_r[k + 8] <= syms_high[k*sirdx_pkg::SYM_W +: sirdx_pkg::SYM_W];
      end
    end else if (left_r != '0) begin
      for (int k = 0; k < sirdx_pkg::MAX_RADIX - 1; k++) sh_r[k] <= sh_r[k+1];
      sh_r[sirdx_pkg::MAX_RADIX-1] <= '0;
    end
  end

  assign bad = bad_r;

endmodule

### rtl/core/signed_int_to_radix_digits_unit.sv
// Signed integer to radix digits, one request at a time: the magnitude is shifted
// into the digit array a bit a cycle, then leading zero positions are skipped or
// digits emitted, and '-' is emitted first for a negative number. Output stalls
// hold the sign and digit emission. A new request is taken only once the last
// symbol is registered, or once the magnitude is in when an invalid base yields
// nothing. Synchronous active-low reset sets defaults.
module signed_int_to_radix_digits_unit (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [sirdx_pkg::NUMBER_WIDTH-1:0] in_number,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [sirdx_pkg::SYM_W-1:0]               out_symbol,
  output logic                                      out_last,
  input  logic                                      cfg_we,
  input  logic [sirdx_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [sirdx_pkg::CFG_W-1:0]               cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_SIGN, S_EMIT} state_t;

  state_t                            state_r, state_nxt;
  logic [sirdx_pkg::BCNT_W-1:0]      bit_cnt_r, bit_cnt_nxt;
  logic [sirdx_pkg::DCNT_W-1:0]      emit_cnt_r, emit_cnt_nxt;
  logic                              neg_r, neg_nxt;
  logic                              started_r, started_nxt;
  logic                              out_valid_r, out_valid_nxt;
  sirdx_pkg::sym_t                   out_symbol_r, out_symbol_nxt;
  logic                              out_last_r, out_last_nxt;

  sirdx_pkg::radix_t                 radix_r;
  sirdx_pkg::cfg_word_t              syms_low_r;
  sirdx_pkg::cfg_word_t              syms_high_r;

  logic                              accept;
  logic                              slot_free;
  logic                              skip;
  logic                              emit_take;
  logic                              num_neg;
  logic [sirdx_pkg::NUMBER_WIDTH-1:0] num_u;
  logic [sirdx_pkg::NUMBER_WIDTH-1:0] mag;
  sirdx_pkg::dig_ctl_t               dig_ctl;
  sirdx_pkg::digit_t                 top_digit;
  logic                              base_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= sirdx_pkg::RADIX_RESET;
      syms_low_r  <= sirdx_pkg::SYMS_LOW_RESET;
      syms_high_r <= sirdx_pkg::SYMS_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sirdx_pkg::CFG_RADIX:     radix_r     <= cfg_data[sirdx_pkg::RADIX_W-1:0];
        sirdx_pkg::CFG_SYMS_LOW:  syms_low_r  <= cfg_data;
        sirdx_pkg::CFG_SYMS_HIGH: syms_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign num_u   = in_number;
  assign num_neg = num_u[sirdx_pkg::NUMBER_WIDTH-1];
  assign mag     = num_neg ? (~num_u + sirdx_pkg::NUMBER_WIDTH'(1)) : num_u;

  // Leading zero digits are dropped before the first digit, keeping at least one.
  assign skip      = (state_r == S_EMIT) && !started_r && (top_digit == '0) &&
                     (emit_cnt_r != sirdx_pkg::DCNT_W'(1));
  assign emit_take = (state_r == S_EMIT) && !skip && slot_free;

  assign dig_ctl.load  = accept;
  assign dig_ctl.conv  = (state_r == S_CONV);
  assign dig_ctl.shift = skip || emit_take;

  sirdx_digits u_digits (
    .clk       (clk),
    .ctl       (dig_ctl),
    .mag_in    (mag),
    .radix     (radix_r),
    .top_digit (top_digit)
  );

  sirdx_symchk u_symchk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .radix     (radix_r),
    .syms_low  (syms_low_r),
    .syms_high (syms_high_r),
    .bad       (base_bad)
  );

  always_comb begin
    state_nxt      = state_r;
    bit_cnt_nxt    = bit_cnt_r;
    emit_cnt_nxt   = emit_cnt_r;
    neg_nxt        = neg_r;
    started_nxt    = started_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt   = S_CONV;
          bit_cnt_nxt = '0;
          neg_nxt     = num_neg;
        end
      end
      S_CONV: begin
        bit_cnt_nxt = bit_cnt_r + sirdx_pkg::BCNT_W'(1);
        if (bit_cnt_r == sirdx_pkg::BCNT_W'(sirdx_pkg::NUMBER_WIDTH - 1)) begin
          emit_cnt_nxt = sirdx_pkg::DCNT_W'(sirdx_pkg::NUM_DIGITS);
          started_nxt  = 1'b0;
          if (base_bad)   state_nxt = S_IDLE;
          else if (neg_r) state_nxt = S_SIGN;
          else            state_nxt = S_EMIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = sirdx_pkg::SIGN_MINUS;
          out_last_nxt   = 1'b0;
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (skip) begin
          emit_cnt_nxt = emit_cnt_r - sirdx_pkg::DCNT_W'(1);
        end else if (emit_take) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = sirdx_pkg::symbol_at(syms_low_r, syms_high_r, top_digit);
          out_last_nxt   = (emit_cnt_r == sirdx_pkg::DCNT_W'(1));
          emit_cnt_nxt   = emit_cnt_r - sirdx_pkg::DCNT_W'(1);
          started_nxt    = 1'b1;
          if (emit_cnt_r == sirdx_pkg::DCNT_W'(1)) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_cnt_r   <= '0;
      emit_cnt_r  <= '0;
      neg_r       <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      neg_r       <= neg_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

### rtl/core/sirdx_chk.sv
// Port-level checker for the radix conversion unit, bound to the top level.
// Depends on sirdx_pkg and the assertion macro header.
`include "signed_int_to_radix_digits_unit_macros.svh"

module sirdx_chk (
  input logic                                      clk,
  input logic                                      rst_n,
  input logic                                      in_valid,
  input logic                                      in_ready,
  input logic signed [sirdx_pkg::NUMBER_WIDTH-1:0] in_number,
  input logic                                      out_valid,
  input logic                                      out_ready,
  input logic [sirdx_pkg::SYM_W-1:0]               out_symbol,
  input logic                                      out_last,
  input logic                                      cfg_we,
  input logic [sirdx_pkg::CFG_IDX_W-1:0]           cfg_index,
  input logic [sirdx_pkg::CFG_W-1:0]               cfg_data
);

  // A stalled result keeps its place and its contents.
  `SIRDX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                     out_valid && $stable(out_symbol) && $stable(out_last),
                     "stalled result changed")

  // Conversion is busy for many cycles, so a request is never taken twice in a row.
  `SIRDX_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready,
                     "request taken while converting")

  // The minus sign always precedes at least one digit.
  `SIRDX_ASSERT_NOW(a_minus_not_last,
                    out_valid && (out_symbol == sirdx_pkg::SIGN_MINUS), !out_last,
                    "minus sign marked last")

  // Digits are never the minus byte, so a delivered minus is not followed by another.
  `SIRDX_ASSERT_NEXT(a_minus_once,
                     out_valid && out_ready && (out_symbol == sirdx_pkg::SIGN_MINUS),
                     !(out_valid && (out_symbol == sirdx_pkg::SIGN_MINUS)),
                     "minus sign repeated")

endmodule

bind signed_int_to_radix_digits_unit sirdx_chk u_sirdx_chk (.*);
